>>> hw/rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> hw/rtl/itnb_pkg.sv
// package: shared types, constants and codes of the idle timeout notifier bank
package itnb_pkg;

   localparam int SLOT_COUNT_DEF   = 32;
   localparam int INHIBIT_BITS_DEF = 16;
   localparam int MAX_RESULTS      = 32;
   localparam int QUEUE_DEPTH      = 2;

   localparam logic [2:0] FUNC_TICK     = 3'd0;
   localparam logic [2:0] FUNC_ACTIVITY = 3'd1;
   localparam logic [2:0] FUNC_CREATE   = 3'd2;
   localparam logic [2:0] FUNC_DESTROY  = 3'd3;
   localparam logic [2:0] FUNC_INH_ADD  = 3'd4;
   localparam logic [2:0] FUNC_INH_DEL  = 3'd5;

   localparam logic [1:0] EV_IDLED   = 2'd0;
   localparam logic [1:0] EV_RESUMED = 2'd1;
   localparam logic [1:0] EV_CREATED = 2'd2;
   localparam logic [1:0] EV_FULL    = 2'd3;

   typedef struct packed {
      logic [2:0]  func;
      logic [4:0]  slot_index;
      logic [31:0] idle_limit;
   } req_type;

   typedef struct packed {
      logic [1:0] event_kind;
      logic [4:0] event_slot;
      logic       last_event;
   } rsp_type;

   // classified command handed from front to back
   typedef struct packed {
      logic        is_tick;
      logic        is_activity;
      logic        is_create;
      logic        is_destroy;
      logic        is_inh_add;
      logic        is_inh_del;
      logic [7:0]  slot_index;
      logic [31:0] idle_limit;
   } cmd_type;

endpackage

>>> hw/rtl/itnb_ram.sv
// generic ram with one write port and one registered read port
module itnb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

>>> hw/rtl/itnb_front.sv
// front part: classifies requests and queues commands for the back part
module itnb_front
   import itnb_pkg::*;
#(
   parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    cmd_valid,
   input  logic    cmd_take,
   output cmd_type cmd_data
);

   cmd_type    q_ff [QUEUE_DEPTH];
   logic [1:0] count_ff, count_in;
   logic       rd_ff, wr_ff;
   cmd_type    cls;
   logic       push, pop;

   // classify the incoming request
   always_comb begin
      cls = '0;
      cls.is_tick     = (req_data.func == FUNC_TICK);
      cls.is_activity = (req_data.func == FUNC_ACTIVITY);
      cls.is_create   = (req_data.func == FUNC_CREATE);
      cls.is_destroy  = (req_data.func == FUNC_DESTROY)
                        && ({4'd0, req_data.slot_index} < 9'(SLOT_COUNT));
      cls.is_inh_add  = (req_data.func == FUNC_INH_ADD);
      cls.is_inh_del  = (req_data.func == FUNC_INH_DEL);
      cls.slot_index  = {3'd0, req_data.slot_index};
      cls.idle_limit  = (req_data.idle_limit == 32'd0) ? 32'd1 : req_data.idle_limit;
   end

   assign req_stall = (count_ff == 2'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (count_ff != 2'd0);
   assign pop       = cmd_valid && cmd_take;
   assign cmd_data  = q_ff[rd_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   // command queue
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rd_ff    <= 1'b0;
         wr_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ff <= !wr_ff;
         end
         if (pop) begin
            rd_ff <= !rd_ff;
         end
      end
      if (push) begin
         q_ff[wr_ff] <= cls;
      end
   end

endmodule

>>> hw/rtl/itnb_back.sv
// back part: sequencer that executes commands, scans the slots and emits events
module itnb_back
   import itnb_pkg::*;
#(
   parameter int SLOT_COUNT   = SLOT_COUNT_DEF,
   parameter int INHIBIT_BITS = INHIBIT_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   output logic    cmd_take,
   input  cmd_type cmd_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CW = $clog2(SLOT_COUNT + 1);
   localparam int NW = $clog2(MAX_RESULTS + 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_EVAL, ST_EMIT, ST_FLUSH
   } state_type;

   state_type                state_ff;
   cmd_type                  cmd_ff;
   logic [IW-1:0]            idx_ff;
   logic [31:0]              time_ff, act_ff;
   logic [INHIBIT_BITS-1:0]  inh_ff;
   logic [SLOT_COUNT-1:0]    valid_ff, idled_ff, armed_ff;
   logic [NW-1:0]            n_ff;
   logic                     pend_ff;
   rsp_type                  pend_data_ff;
   logic                     out_valid_ff;
   rsp_type                  out_data_ff;
   logic                     emit_ok_ff;
   rsp_type                  emit_data_ff;

   // memories for timeout and remaining time
   logic          tmo_we, rem_we;
   logic [IW-1:0] tmo_wa, rem_wa;
   logic [31:0]   tmo_wd, rem_wd, tmo_rd, rem_rd;

   itnb_ram #(.WIDTH(32), .DEPTH(SLOT_COUNT)) u_tmo_ram (
      .clock(clock), .wr_en(tmo_we), .wr_addr(tmo_wa), .wr_data(tmo_wd),
      .rd_addr(idx_ff), .rd_data(tmo_rd)
   );
   itnb_ram #(.WIDTH(32), .DEPTH(SLOT_COUNT)) u_rem_ram (
      .clock(clock), .wr_en(rem_we), .wr_addr(rem_wa), .wr_data(rem_wd),
      .rd_addr(idx_ff), .rd_data(rem_rd)
   );

   // lowest free slot for create
   logic [IW-1:0] free_idx;
   logic          free_any;
   always_comb begin
      free_idx = '0;
      free_any = 1'b0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = IW'(i);
            free_any = 1'b1;
         end
      end
   end

   // per slot evaluation for tick and activity
   logic [31:0] rem_dec, elapsed;
   logic        sel_valid, sel_idled, sel_armed;
   logic        ev_gen, ev_idle_set, ev_disarm, ev_rem_we, ev_resume;
   logic [31:0] ev_rem;
   always_comb begin
      sel_valid   = valid_ff[idx_ff];
      sel_idled   = idled_ff[idx_ff];
      sel_armed   = armed_ff[idx_ff];
      rem_dec     = (rem_rd != 32'd0) ? rem_rd - 32'd1 : 32'd0;
      elapsed     = time_ff - act_ff;
      ev_gen      = 1'b0;
      ev_idle_set = 1'b0;
      ev_disarm   = 1'b0;
      ev_rem_we   = 1'b0;
      ev_resume   = 1'b0;
      ev_rem      = rem_dec;
      if (cmd_ff.is_tick && sel_valid && sel_armed) begin
         ev_rem_we = 1'b1;
         if (rem_dec == 32'd0) begin
            if (inh_ff != '0) begin
               ev_rem = tmo_rd;
            end else if (elapsed < tmo_rd) begin
               ev_rem = tmo_rd - elapsed;
            end else begin
               ev_disarm = 1'b1;
               if (!sel_idled) begin
                  ev_idle_set = 1'b1;
                  ev_gen      = 1'b1;
               end
            end
         end
      end else if (cmd_ff.is_activity && sel_valid && sel_idled) begin
         ev_resume = 1'b1;
         ev_gen    = 1'b1;
         ev_rem_we = 1'b1;
         ev_rem    = tmo_rd;
      end
   end

   logic emit_new;
   logic out_free;
   logic out_load;
   logic scan_last;
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign scan_last = (CW'(idx_ff) == CW'(SLOT_COUNT - 1));
   assign cmd_take  = (state_ff == ST_IDLE) && cmd_valid;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // output register load from the held-back event
   always_comb begin
      out_load = 1'b0;
      if (state_ff == ST_EMIT) begin
         out_load = emit_ok_ff && pend_ff && out_free;
      end else if (state_ff == ST_FLUSH) begin
         out_load = pend_ff && out_free;
      end
   end

   // ram write ports
   always_comb begin
      tmo_we = 1'b0;
      tmo_wa = free_idx;
      tmo_wd = cmd_data.idle_limit;
      rem_we = 1'b0;
      rem_wa = idx_ff;
      rem_wd = ev_rem;
      emit_new = 1'b0;
      if (cmd_take && cmd_data.is_create && free_any) begin
         tmo_we = 1'b1;
         rem_we = 1'b1;
         rem_wa = free_idx;
         rem_wd = cmd_data.idle_limit;
      end else if (state_ff == ST_EVAL) begin
         rem_we   = ev_rem_we;
         emit_new = ev_gen;
      end
   end

   // control sequencer and slot state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         time_ff      <= '0;
         act_ff       <= '0;
         inh_ff       <= '0;
         valid_ff     <= '0;
         idled_ff     <= '0;
         armed_ff     <= '0;
         out_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         emit_ok_ff   <= 1'b0;
         n_ff         <= '0;
         idx_ff       <= '0;
      end else begin
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (out_valid_ff && !rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (cmd_take) begin
                  cmd_ff  <= cmd_data;
                  idx_ff  <= '0;
                  n_ff    <= '0;
                  pend_ff <= cmd_data.is_create;
                  if (cmd_data.is_tick) begin
                     time_ff  <= time_ff + 32'd1;
                     state_ff <= ST_READ;
                  end else if (cmd_data.is_activity) begin
                     act_ff   <= time_ff;
                     state_ff <= ST_READ;
                  end else if (cmd_data.is_create) begin
                     if (free_any) begin
                        valid_ff[free_idx] <= 1'b1;
                        idled_ff[free_idx] <= 1'b0;
                        armed_ff[free_idx] <= 1'b1;
                        pend_data_ff <= '{EV_CREATED, 5'(free_idx), 1'b1};
                     end else begin
                        pend_data_ff <= '{EV_FULL, 5'd0, 1'b1};
                     end
                     state_ff <= ST_FLUSH;
                  end else if (cmd_data.is_destroy) begin
                     if (valid_ff[IW'(cmd_data.slot_index)]) begin
                        valid_ff[IW'(cmd_data.slot_index)] <= 1'b0;
                        idled_ff[IW'(cmd_data.slot_index)] <= 1'b0;
                        armed_ff[IW'(cmd_data.slot_index)] <= 1'b0;
                     end
                  end else if (cmd_data.is_inh_add) begin
                     if (inh_ff != '1) begin
                        inh_ff <= inh_ff + 1'b1;
                     end
                  end else if (cmd_data.is_inh_del) begin
                     if (inh_ff != '0) begin
                        inh_ff <= inh_ff - 1'b1;
                     end
                  end
               end
            end
            ST_READ: begin
               state_ff <= ST_EVAL;
            end
            ST_EVAL: begin
               if (ev_idle_set) idled_ff[idx_ff] <= 1'b1;
               if (ev_disarm)   armed_ff[idx_ff] <= 1'b0;
               if (ev_resume) begin
                  idled_ff[idx_ff] <= 1'b0;
                  armed_ff[idx_ff] <= 1'b1;
               end
               emit_ok_ff   <= emit_new && (n_ff < NW'(MAX_RESULTS));
               emit_data_ff <= '{ev_resume ? EV_RESUMED : EV_IDLED, 5'(idx_ff), 1'b0};
               state_ff     <= ST_EMIT;
            end
            ST_EMIT: begin
               // hold back one event so the final one can be marked
               if (!emit_ok_ff || !pend_ff || out_free) begin
                  if (emit_ok_ff) begin
                     if (pend_ff) begin
                        out_data_ff <= pend_data_ff;
                     end
                     pend_ff      <= 1'b1;
                     pend_data_ff <= '{emit_data_ff.event_kind, emit_data_ff.event_slot,
                                       scan_last};
                     n_ff         <= n_ff + 1'b1;
                  end else if (scan_last) begin
                     pend_data_ff.last_event <= 1'b1;
                  end
                  if (scan_last) begin
                     state_ff <= ST_FLUSH;
                  end else begin
                     idx_ff   <= idx_ff + 1'b1;
                     state_ff <= ST_READ;
                  end
               end
            end
            ST_FLUSH: begin
               if (!pend_ff) begin
                  state_ff <= ST_IDLE;
               end else if (out_free) begin
                  out_data_ff  <= pend_data_ff;
                  pend_ff      <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

>>> hw/rtl/idle_timeout_notifier_bank.sv
// Idle timeout notifier bank, top level.
// Create moves its result via the flush state into the output register; tick and
// activity run a sequential slot scan through read, eval and emit states per slot.
// Throughput: one scan per tick or activity; destroy and inhibitor stay in idle.
// A two-entry command queue lets requests be taken while the scan runs.
// Reset: synchronous; clears time, inhibitor count and slot flags.
module idle_timeout_notifier_bank
   import itnb_pkg::*;
#(
   parameter int SLOT_COUNT   = SLOT_COUNT_DEF,
   parameter int INHIBIT_BITS = INHIBIT_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    cmd_valid, cmd_take;
   cmd_type cmd_data;

   itnb_front #(.SLOT_COUNT(SLOT_COUNT)) u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd_data(cmd_data)
   );

   itnb_back #(.SLOT_COUNT(SLOT_COUNT), .INHIBIT_BITS(INHIBIT_BITS)) u_back (
      .clock(clock), .reset(reset),
      .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd_data(cmd_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

endmodule

>>> hw/rtl/itnb_checker.sv
// port checker for the idle timeout notifier bank, with its bind
`include "assert_macros.svh"
module itnb_checker
   import itnb_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   logic rsp_full, rsp_created;
   assign rsp_full    = rsp_valid && (rsp_data.event_kind == EV_FULL);
   assign rsp_created = rsp_valid && (rsp_data.event_kind == EV_CREATED);

   `ASSERT_NEXT(a_req_hold, clock, reset, req_valid && req_stall, req_valid && $stable(req_data))
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   `ASSERT_IMPL(a_full_slot0, clock, reset, rsp_full, rsp_data.event_slot == 5'd0 && rsp_data.last_event)
   `ASSERT_IMPL(a_create_last, clock, reset, rsp_created, rsp_data.last_event)
   `ASSERT_NEXT(a_no_rsp_after_reset, clock, 1'b0, reset, !rsp_valid)

endmodule

bind idle_timeout_notifier_bank itnb_checker u_itnb_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);

>>> sim/tb.sv
// testbench for the idle timeout notifier bank: directed table then random traffic
`timescale 1ns / 100ps

module tb;
   import itnb_pkg::*;

   localparam int NSLOT = 32;
   localparam int INH_MAX = 65535;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 3 * NSLOT + 20;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   idle_timeout_notifier_bank DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // predictor state
   logic [31:0] now_ms, last_act_ms;
   logic [15:0] inh_count;
   logic        s_valid [NSLOT];
   logic        s_idled [NSLOT];
   logic        s_armed [NSLOT];
   logic [31:0] s_timeout [NSLOT];
   logic [31:0] s_remain [NSLOT];

   rsp_type events_due [$];
   int      fail_count = 0;
   int      quiet_cycles = 0;
   bit      no_idle = 1'b0;

   // directed stimulus with optional typed expectation
   typedef struct {
      req_type req;
      bit      has_exp;
      rsp_type exp;
   } row_type;

   function automatic rsp_type mk_event(logic [1:0] k, int s);
      rsp_type r;
      r.event_kind = k;
      r.event_slot = s[4:0];
      r.last_event = 1'b0;
      return r;
   endfunction

   // work out the events caused by one request and update predicted state
   function automatic void predict_events(req_type q);
      rsp_type ev [$];
      logic [31:0] elapsed;
      int free_slot;
      case (q.func)
         FUNC_TICK: begin
            now_ms = now_ms + 1;
            for (int i = 0; i < NSLOT; i++) begin
               if (!s_valid[i] || !s_armed[i]) continue;
               if (s_remain[i] > 0) s_remain[i] = s_remain[i] - 1;
               if (s_remain[i] != 0) continue;
               elapsed = now_ms - last_act_ms;
               if (inh_count > 0) s_remain[i] = s_timeout[i];
               else if (elapsed < s_timeout[i]) s_remain[i] = s_timeout[i] - elapsed;
               else begin
                  if (!s_idled[i]) begin
                     s_idled[i] = 1'b1;
                     ev.push_back(mk_event(EV_IDLED, i));
                  end
                  s_armed[i] = 1'b0;
               end
            end
         end
         FUNC_ACTIVITY: begin
            last_act_ms = now_ms;
            for (int i = 0; i < NSLOT; i++) begin
               if (!s_valid[i] || !s_idled[i]) continue;
               s_idled[i] = 1'b0;
               s_armed[i] = 1'b1;
               s_remain[i] = s_timeout[i];
               ev.push_back(mk_event(EV_RESUMED, i));
            end
         end
         FUNC_CREATE: begin
            free_slot = -1;
            for (int i = NSLOT - 1; i >= 0; i--) if (!s_valid[i]) free_slot = i;
            if (free_slot < 0) ev.push_back(mk_event(EV_FULL, 0));
            else begin
               s_valid[free_slot] = 1'b1;
               s_idled[free_slot] = 1'b0;
               s_armed[free_slot] = 1'b1;
               s_timeout[free_slot] = (q.idle_limit == 0) ? 32'd1 : q.idle_limit;
               s_remain[free_slot] = s_timeout[free_slot];
               ev.push_back(mk_event(EV_CREATED, free_slot));
            end
         end
         FUNC_DESTROY: begin
            if (s_valid[q.slot_index]) begin
               s_valid[q.slot_index] = 1'b0;
               s_idled[q.slot_index] = 1'b0;
               s_armed[q.slot_index] = 1'b0;
            end
         end
         FUNC_INH_ADD: if (inh_count != INH_MAX) inh_count = inh_count + 1;
         FUNC_INH_DEL: if (inh_count != 0) inh_count = inh_count - 1;
         default: ;
      endcase
      if (ev.size() > 0) ev[ev.size() - 1].last_event = 1'b1;
      foreach (ev[k]) events_due.push_back(ev[k]);
   endfunction

   function automatic req_type mk_req(logic [2:0] f, logic [4:0] s, logic [31:0] t);
      req_type q;
      q.func = f;
      q.slot_index = s;
      q.idle_limit = t;
      return q;
   endfunction

   // drive one transfer on the request side, with an optional idle burst first
   task automatic send_req(req_type q);
      int gap;
      if (!no_idle && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 18);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= q;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_events(q);
   endtask

   // random stall bursts on the result side
   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!no_idle && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 18)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // compare each result transfer with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (events_due.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %p", $time, rsp_data);
            fail_count++;
         end else begin
            if (rsp_data !== events_due[0]) begin
               $display("%0t: result mismatch, expected %p, actual %p",
                        $time, events_due[0], rsp_data);
               fail_count++;
            end
            void'(events_due.pop_front());
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic random_req();
      int pick;
      logic [31:0] t;
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 3))
         0: t = $urandom();
         1: t = 0;
         default: t = $urandom_range(1, 12);
      endcase
      if (pick < 50) send_req(mk_req(FUNC_TICK, $urandom(), $urandom()));
      else if (pick < 62) send_req(mk_req(FUNC_ACTIVITY, $urandom(), $urandom()));
      else if (pick < 77) send_req(mk_req(FUNC_CREATE, $urandom(), t));
      else if (pick < 87) send_req(mk_req(FUNC_DESTROY, $urandom(), $urandom()));
      else if (pick < 92) send_req(mk_req(FUNC_INH_ADD, $urandom(), $urandom()));
      else if (pick < 97) send_req(mk_req(FUNC_INH_DEL, $urandom(), $urandom()));
      else send_req(mk_req(3'($urandom_range(6, 7)), $urandom(), $urandom()));
   endtask

   initial begin
      row_type rows [$];
      row_type r;
      int waited;
      now_ms = 0; last_act_ms = 0; inh_count = 0;
      for (int i = 0; i < NSLOT; i++) begin
         s_valid[i] = 0; s_idled[i] = 0; s_armed[i] = 0;
         s_timeout[i] = 0; s_remain[i] = 0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table: extremes, every func, zero timeout, inhibitor lower limit
      r.has_exp = 1; r.exp = '0;
      r.req = mk_req(FUNC_CREATE, 5'd31, 32'd0);
      r.exp = mk_event(EV_CREATED, 0); r.exp.last_event = 1; rows.push_back(r);
      r.req = mk_req(FUNC_CREATE, 5'd0, 32'hFFFF_FFFF);
      r.exp = mk_event(EV_CREATED, 1); r.exp.last_event = 1; rows.push_back(r);
      r.has_exp = 0;
      r.req = mk_req(FUNC_INH_DEL, 5'd31, 32'hFFFF_FFFF); rows.push_back(r);
      r.req = mk_req(FUNC_TICK, 5'd0, 32'd0); rows.push_back(r);
      r.req = mk_req(FUNC_TICK, 5'd0, 32'd0); rows.push_back(r);
      r.req = mk_req(FUNC_ACTIVITY, 5'd0, 32'd0); rows.push_back(r);
      r.req = mk_req(FUNC_INH_ADD, 5'd0, 32'd0); rows.push_back(r);
      r.req = mk_req(FUNC_TICK, 5'd0, 32'd0); rows.push_back(r);
      r.req = mk_req(FUNC_INH_DEL, 5'd0, 32'd0); rows.push_back(r);
      r.req = mk_req(FUNC_DESTROY, 5'd1, 32'd0); rows.push_back(r);
      r.req = mk_req(FUNC_DESTROY, 5'd31, 32'd0); rows.push_back(r);
      r.req = mk_req(3'd6, 5'd0, 32'd0); rows.push_back(r);
      r.req = mk_req(3'd7, 5'h1F, 32'hFFFF_FFFF); rows.push_back(r);
      r.req = mk_req(FUNC_CREATE, 5'd0, 32'd3); rows.push_back(r);
      r.req = mk_req(FUNC_TICK, 5'd0, 32'd0); rows.push_back(r);
      r.req = mk_req(FUNC_TICK, 5'd0, 32'd0); rows.push_back(r);
      r.req = mk_req(FUNC_TICK, 5'd0, 32'd0); rows.push_back(r);
      r.req = mk_req(FUNC_TICK, 5'd0, 32'd0); rows.push_back(r);
      r.req = mk_req(FUNC_ACTIVITY, 5'd0, 32'd0); rows.push_back(r);
      foreach (rows[k]) begin
         send_req(rows[k].req);
         if (rows[k].has_exp) begin
            // typed row: the newest expectation must match, the monitor checks the block
            if (events_due.size() == 0 || events_due[$] !== rows[k].exp) begin
               $display("%0t: table row %0d, expected %p, actual %p",
                        $time, k, rows[k].exp, events_due.size() ? events_due[$] : '0);
               fail_count++;
            end
         end
      end

      // fill the table to get a full result, then pause until all results arrive
      for (int i = 0; i < 34; i++) send_req(mk_req(FUNC_CREATE, 5'd0, 32'd2));
      req_valid <= 1'b0;
      while (events_due.size() != 0) @(posedge clock);
      // slots with the same timeout expire on the same tick: a burst of events
      repeat (3) send_req(mk_req(FUNC_TICK, 5'd0, 32'd0));
      send_req(mk_req(FUNC_ACTIVITY, 5'd0, 32'd0));
      for (int i = 0; i < NSLOT; i++) send_req(mk_req(FUNC_DESTROY, 5'(i), 32'd0));
      // inhibitor saturation at the top, in the predictor only
      for (int i = 0; i < INH_MAX + 1; i++) predict_events(mk_req(FUNC_INH_ADD, 0, 0));
      inh_count = 0;

      // random part, last stretch without idling
      for (int n = 0; n < 280; n++) begin
         if (n == 240) no_idle = 1'b1;
         random_req();
      end
      req_valid <= 1'b0;

      waited = 0;
      while (events_due.size() != 0 && waited < WATCHDOG_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && events_due.size() == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/itnb_pkg.sv
hw/rtl/itnb_ram.sv
hw/rtl/itnb_front.sv
hw/rtl/itnb_back.sv
hw/rtl/idle_timeout_notifier_bank.sv
hw/rtl/itnb_checker.sv
sim/tb.sv
